// File: hw/rtl/motion_sleep_wake_detector_macros.svh
// Assertion macros for the motion sleep/wake detector checker.
// No dependencies; included by files that assert.
`ifndef MOTION_SLEEP_WAKE_DETECTOR_MACROS_SVH
`define MOTION_SLEEP_WAKE_DETECTOR_MACROS_SVH

// Same-cycle implication, off while in reset.
`define MSWD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("motion sleep/wake detector check failed");

// Next-cycle implication, off while in reset.
`define MSWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("motion sleep/wake detector check failed");

// Next-cycle implication that also holds across reset.
`define MSWD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("motion sleep/wake detector check failed");

`endif

// File: hw/rtl/mswd_pkg.sv
// Shared types, constants and helper functions of the motion sleep/wake detector.
// No dependencies.
package mswd_pkg;

    localparam int AXES        = 6;
    localparam int AXIS_W      = 16;
    localparam int TIME_W      = 32;
    localparam int THR_W       = 19;
    localparam int HOLD_W      = 8;
    localparam int HOLD_SEC_W  = 14;   // 255 minutes * 60 fits in 14 bits
    localparam int MAG_W       = 19;
    localparam int EV_W        = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int S_DATA_W    = 128;
    localparam int M_DATA_W    = 24;

    // Event codes
    localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EV_W-1:0] EV_SLEEP = 2'd1;
    localparam logic [EV_W-1:0] EV_WAKE  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_HOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_HOLD  = 2'd2;

    localparam logic [THR_W-1:0]  STILL_THR_RST  = 19'd500;
    localparam logic [HOLD_W-1:0] SLEEP_HOLD_RST = 8'd10;
    localparam logic [HOLD_W-1:0] WAKE_HOLD_RST  = 8'd1;

    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef axis_t [AXES-1:0] axes_t;   // element 0 is accel_x

    // Input item, laid out as on s_tdata (accel_x lowest)
    typedef struct packed {
        logic [TIME_W-1:0] now_seconds;
        axes_t             axes;
    } sample_t;

    typedef struct packed {
        logic have_prev;
        logic sleeping;
    } mode_t;

    function automatic logic [AXIS_W-1:0] abs_diff(input axis_t a, input axis_t b);
        logic signed [AXIS_W:0] d;
        logic [AXIS_W:0]        n;
        d = {a[AXIS_W-1], a} - {b[AXIS_W-1], b};
        n = -d;
        return d[AXIS_W] ? n[AXIS_W-1:0] : d[AXIS_W-1:0];
    endfunction

    // minutes * 60 as (m << 6) - (m << 2)
    function automatic logic [HOLD_SEC_W-1:0] mins_to_secs(input logic [HOLD_W-1:0] m);
        logic [HOLD_SEC_W-1:0] w;
        w = {{(HOLD_SEC_W-HOLD_W){1'b0}}, m};
        return (w << 6) - (w << 2);
    endfunction

endpackage

// File: hw/rtl/motion_sleep_wake_detector.sv
// Top level of the motion sleep/wake detector: handshake, registers, hold timers.
// Depends on mswd_pkg and mswd_mag.
//
//  channel | dir | tdata fields (lowest bit up)                        | width
//  --------+-----+-----------------------------------------------------+------
//  s_      | in  | accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,  | 128
//          |     | now_seconds                                         |
//  m_      | out | asleep, event_res, magnitude, 2 zero bits           | 24
//  cfg_    | in  | index 0 still_threshold, 1 sleep/2 wake hold mins   | 19
//
// One item per cycle sustained while m_tready is high. An accepted item is held in the
// input register, where magnitude, timer and sleep state are worked out in a single pass;
// its result moves into the output register once that register is free or being read.
// s_tready drops only when both registers are full and m_tready is low.
// aresetn is synchronous, active low: both stages empty, awake, timers unarmed,
// registers back to 500 / 10 / 1.
module motion_sleep_wake_detector (
    input  logic                              aclk,
    input  logic                              aresetn,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, now_seconds
    input  logic [mswd_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // asleep, event_res, magnitude, zero pad
    output logic [mswd_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_wr_en,
    input  logic [mswd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mswd_pkg::THR_W-1:0]        cfg_data
);
    import mswd_pkg::*;

    // configuration
    logic [THR_W-1:0]  still_thr_reg;
    logic [HOLD_W-1:0] sleep_hold_reg;
    logic [HOLD_W-1:0] wake_hold_reg;

    // input stage
    logic    in_vld_reg, in_vld_next;
    sample_t in_item_reg;

    // detector state
    axes_t             prev_reg;
    logic              have_prev_reg;
    logic              sleeping_reg, sleeping_next;
    logic [TIME_W-1:0] still_since_reg, still_since_next;
    logic [TIME_W-1:0] active_since_reg, active_since_next;

    // output stage
    logic              out_vld_reg, out_vld_next;
    logic              out_asleep_reg;
    logic [EV_W-1:0]   out_event_reg;
    logic [MAG_W-1:0]  out_mag_reg;

    logic              advance;
    logic              s_fire;
    logic              m_fire;
    mode_t             mode;
    logic [MAG_W-1:0]  mag;
    logic [EV_W-1:0]   ev;
    logic [TIME_W-1:0] still_elapsed;
    logic [TIME_W-1:0] active_elapsed;
    logic [TIME_W-1:0] sleep_hold_s;
    logic [TIME_W-1:0] wake_hold_s;
    logic [THR_W:0]    active_thr;

    // handshake: the input register moves on whenever the output register is empty or being read out
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || !out_vld_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = out_vld_reg && m_tready;

    assign in_vld_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = advance ? 1'b1 : (m_fire ? 1'b0 : out_vld_reg);

    assign mode.have_prev = have_prev_reg;
    assign mode.sleeping  = sleeping_reg;

    mswd_mag u_mag (
        .cur  (in_item_reg.axes),
        .prev (prev_reg),
        .mode (mode),
        .mag  (mag)
    );

    assign still_elapsed  = in_item_reg.now_seconds - still_since_reg;
    assign active_elapsed = in_item_reg.now_seconds - active_since_reg;
    assign sleep_hold_s   = {{(TIME_W-HOLD_SEC_W){1'b0}}, mins_to_secs(sleep_hold_reg)};
    assign wake_hold_s    = {{(TIME_W-HOLD_SEC_W){1'b0}}, mins_to_secs(wake_hold_reg)};
    assign active_thr     = {still_thr_reg, 1'b0};

    // Hold timers. A start time of zero means unarmed; the first qualifying item
    // arms it, a later one past the hold time flips the state and disarms.
    always_comb begin
        ev                = EV_NONE;
        sleeping_next     = sleeping_reg;
        still_since_next  = still_since_reg;
        active_since_next = active_since_reg;
        if (have_prev_reg) begin
            if (!sleeping_reg) begin
                if (mag < still_thr_reg) begin
                    if (still_since_reg == '0) begin
                        still_since_next = in_item_reg.now_seconds;
                    end else if (still_elapsed >= sleep_hold_s) begin
                        sleeping_next    = 1'b1;
                        still_since_next = '0;
                        ev               = EV_SLEEP;
                    end
                end else begin
                    still_since_next = '0;
                end
            end else begin
                if ({1'b0, mag} > active_thr) begin
                    if (active_since_reg == '0) begin
                        active_since_next = in_item_reg.now_seconds;
                    end else if (active_elapsed >= wake_hold_s) begin
                        sleeping_next     = 1'b0;
                        active_since_next = '0;
                        ev                = EV_WAKE;
                    end
                end else begin
                    active_since_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            still_thr_reg  <= STILL_THR_RST;
            sleep_hold_reg <= SLEEP_HOLD_RST;
            wake_hold_reg  <= WAKE_HOLD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_STILL_THR:  still_thr_reg  <= cfg_data;
                CFG_SLEEP_HOLD: sleep_hold_reg <= cfg_data[HOLD_W-1:0];
                CFG_WAKE_HOLD:  wake_hold_reg  <= cfg_data[HOLD_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
            have_prev_reg    <= 1'b0;
            sleeping_reg     <= 1'b0;
            still_since_reg  <= '0;
            active_since_reg <= '0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance) begin
                have_prev_reg    <= 1'b1;
                sleeping_reg     <= sleeping_next;
                still_since_reg  <= still_since_next;
                active_since_reg <= active_since_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= sample_t'(s_tdata);
        end
        if (advance) begin
            prev_reg       <= in_item_reg.axes;
            out_asleep_reg <= sleeping_next;
            out_event_reg  <= ev;
            out_mag_reg    <= mag;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_DATA_W-MAG_W-EV_W-1){1'b0}}, out_mag_reg, out_event_reg,
                       out_asleep_reg};

endmodule

// File: hw/rtl/mswd_mag.sv
// Motion magnitude: sum of absolute axis differences against the previous sample.
// Depends on mswd_pkg.
module mswd_mag (
    input  mswd_pkg::axes_t             cur,
    input  mswd_pkg::axes_t             prev,
    input  mswd_pkg::mode_t             mode,
    output logic [mswd_pkg::MAG_W-1:0]  mag
);
    import mswd_pkg::*;

    logic [AXIS_W-1:0] ad [AXES];
    logic [AXIS_W+1:0] accel_sum;
    logic [AXIS_W+1:0] rate_sum;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            ad[i] = abs_diff(cur[i], prev[i]);
        end
        accel_sum = {2'b00, ad[0]} + {2'b00, ad[1]} + {2'b00, ad[2]};
        rate_sum  = {2'b00, ad[3]} + {2'b00, ad[4]} + {2'b00, ad[5]};
    end

    // gyro only counts while awake; no previous sample means zero
    always_comb begin
        if (!mode.have_prev) begin
            mag = '0;
        end else if (mode.sleeping) begin
            mag = {1'b0, accel_sum};
        end else begin
            mag = {1'b0, accel_sum} + {1'b0, rate_sum};
        end
    end

endmodule

// File: hw/rtl/mswd_checker.sv
// Port-level checks for the motion sleep/wake detector, bound to the top level.
// Depends on mswd_pkg and the assertion macro header.
`include "motion_sleep_wake_detector_macros.svh"

module mswd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic [mswd_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready
);
    import mswd_pkg::*;

    logic              r_asleep;
    logic [EV_W-1:0]   r_event;
    logic [MAG_W-1:0]  r_mag;
    logic              ev_state_ok;

    assign r_asleep = m_tdata[0];
    assign r_event  = m_tdata[EV_W:1];
    assign r_mag    = m_tdata[MAG_W+EV_W:EV_W+1];

    assign ev_state_ok = (r_event == EV_SLEEP && r_asleep) || (r_event == EV_WAKE && !r_asleep);

    // a stalled result holds
    `MSWD_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // an entered-sleep event reports asleep, a wake event reports awake
    `MSWD_ASSERT_IMPLY(a_ev_state, aclk, aresetn, m_tvalid && r_event != EV_NONE, ev_state_ok)
    // six 16-bit differences cannot exceed 6 * 65535
    `MSWD_ASSERT_IMPLY(a_mag_max, aclk, aresetn, m_tvalid, r_mag <= 19'd393210)
    // both stages are empty straight after reset
    `MSWD_ASSERT_NEXT_ALWAYS(a_rst_ready, aclk, !aresetn, s_tready && !m_tvalid)

endmodule

bind motion_sleep_wake_detector mswd_checker u_mswd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// File: tb/tb.sv
// Self-checking bench for motion_sleep_wake_detector: directed and random IMU samples
// through several register settings, each result checked against a built-in model.
// Depends on mswd_pkg and the RTL of the detector.
module tb;
    import mswd_pkg::*;

    localparam int          PIPE_LAT    = 2;      // item in, result out through the input and output registers
    localparam int          STALL_LIMIT = 3000;   // cycles with no traffic before giving up
    localparam int          IDLE_PCT    = 35;
    localparam int          MAX_REPORTS = 10;
    localparam int          AXIS_MAX    = 32767;
    localparam int          AXIS_MIN    = -32768;
    localparam int unsigned SEC_PER_MIN = 60;

    // Not decoded by the block: a write here must leave every register alone
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Result item as it sits in m_tdata[21:0] (asleep in bit 0)
    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [EV_W-1:0]  ev_code;
        logic             asleep;
    } outcome_t;

    logic                    aclk;
    logic                    aresetn   = 1'b0;
    logic [S_DATA_W-1:0]     s_tdata   = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [M_DATA_W-1:0]     m_tdata;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [THR_W-1:0]        cfg_data  = '0;

    motion_sleep_wake_detector uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),     // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, now_seconds
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),     // asleep, event_res, magnitude, zero pad
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------------
    // Bench copies of the registers and of the detector state
    // ---------------------------------------------------------------------
    logic [THR_W-1:0]  cfg_thr       = STILL_THR_RST;
    logic [HOLD_W-1:0] cfg_sleep_min = SLEEP_HOLD_RST;
    logic [HOLD_W-1:0] cfg_wake_min  = WAKE_HOLD_RST;

    axes_t             last_axes  = '0;
    logic              seen_first = 1'b0;
    logic              asleep_st  = 1'b0;
    logic [TIME_W-1:0] still_t0   = '0;     // zero means the timer is unarmed
    logic [TIME_W-1:0] active_t0  = '0;

    sample_t  samples_pending[$];   // items waiting for the driver
    outcome_t outcome_due[$];       // results owed by the block, oldest first

    // Stimulus cursor: the sensor pose and clock that random runs walk from
    axes_t             pose    = '0;
    logic [TIME_W-1:0] clock_s = '0;
    logic              calm    = 1'b0;  // no idling on either side while set

    int n_queued    = 0;
    int n_accepted  = 0;
    int n_checked   = 0;
    int n_sleeps    = 0;
    int n_wakes     = 0;
    int n_settings  = 1;
    int mismatches  = 0;
    int stall_cycles = 0;

    // ---------------------------------------------------------------------
    // Model of one sample: magnitude, hold timers, sleep state
    // ---------------------------------------------------------------------
    function automatic outcome_t sleep_wake_outcome(input sample_t smp);
        outcome_t          res;
        int                diff;
        int unsigned       mag;
        logic [TIME_W-1:0] now;
        res.ev_code = EV_NONE;
        mag = 0;
        now = smp.now_seconds;
        if (seen_first) begin
            // gyro axes (3..5) only count while awake
            for (int k = 0; k < AXES; k++) begin
                if (k < 3 || !asleep_st) begin
                    diff = int'(smp.axes[k]) - int'(last_axes[k]);
                    mag += (diff < 0) ? -diff : diff;
                end
            end
            if (!asleep_st) begin
                // exactly at threshold: neither still nor active, timer dropped
                if (mag < cfg_thr) begin
                    if (still_t0 == 0) begin
                        still_t0 = now;
                    end else if (now - still_t0 >= cfg_sleep_min * SEC_PER_MIN) begin
                        asleep_st   = 1'b1;
                        still_t0    = '0;
                        res.ev_code = EV_SLEEP;
                    end
                end else begin
                    still_t0 = '0;
                end
            end else begin
                if (mag > 2 * cfg_thr) begin
                    if (active_t0 == 0) begin
                        active_t0 = now;
                    end else if (now - active_t0 >= cfg_wake_min * SEC_PER_MIN) begin
                        asleep_st   = 1'b0;
                        active_t0   = '0;
                        res.ev_code = EV_WAKE;
                    end
                end else begin
                    active_t0 = '0;
                end
            end
        end
        last_axes     = smp.axes;   // all six axes kept, asleep or not
        seen_first    = 1'b1;
        res.asleep    = asleep_st;
        res.magnitude = MAG_W'(mag);
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Clock, input side, output side, watchdog
    // ---------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Driver: holds an item until taken, then maybe idles before the next one.
    always @(posedge aclk) begin : drive_samples
        logic taken;
        taken = s_tvalid && s_tready;
        if (taken) begin
            outcome_due.push_back(sleep_wake_outcome(sample_t'(s_tdata)));
            n_accepted++;
        end
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || taken) begin
            if (samples_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                s_tdata  <= samples_pending.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: every result taken is matched against the oldest expectation.
    always @(posedge aclk) begin : check_results
        outcome_t got;
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = outcome_t'(m_tdata[$bits(outcome_t)-1:0]);
            if (got.ev_code == EV_SLEEP) n_sleeps++;
            if (got.ev_code == EV_WAKE)  n_wakes++;
            if (outcome_due.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("tb: result with nothing outstanding: asleep %0b event %0d mag %0d",
                             got.asleep, got.ev_code, got.magnitude);
                mismatches++;
            end else begin
                want = outcome_due.pop_front();
                if (got.asleep !== want.asleep || got.ev_code !== want.ev_code ||
                    got.magnitude !== want.magnitude) begin
                    if (mismatches < MAX_REPORTS)
                        $display("tb: result %0d wrong: asleep %0b/%0b event %0d/%0d mag %0d/%0d (exp/got)",
                                 n_checked, want.asleep, got.asleep, want.ev_code, got.ev_code,
                                 want.magnitude, got.magnitude);
                    mismatches++;
                end
            end
            n_checked++;
        end
    end

    // Watchdog: any handshake or register write counts as progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("tb: no traffic for %0d cycles, %0d results still owed",
                     STALL_LIMIT, outcome_due.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    function automatic axis_t clamp_axis(input int v);
        if (v > AXIS_MAX) return axis_t'(AXIS_MAX);
        if (v < AXIS_MIN) return axis_t'(AXIS_MIN);
        return axis_t'(v);
    endfunction

    task automatic queue_sample(input axes_t ax, input logic [TIME_W-1:0] t);
        sample_t smp;
        smp.axes        = ax;
        smp.now_seconds = t;
        samples_pending.push_back(smp);
        n_queued++;
    endtask

    // Directed items: set the whole pose and the clock explicitly
    task automatic queue_pose(input int ax, input int ay, input int az,
                              input int rx, input int ry, input int rz,
                              input logic [TIME_W-1:0] t);
        pose[0] = axis_t'(ax);
        pose[1] = axis_t'(ay);
        pose[2] = axis_t'(az);
        pose[3] = axis_t'(rx);
        pose[4] = axis_t'(ry);
        pose[5] = axis_t'(rz);
        clock_s = t;
        queue_sample(pose, clock_s);
    endtask

    // Small wander that stays under the threshold; now and then a gyro-only swing,
    // invisible while asleep but enough to break stillness while awake
    task automatic still_stretch(input int len);
        int          amp;
        int          d;
        int unsigned step_hi;
        amp = (cfg_thr > 12) ? (int'(cfg_thr) - 1) / 6 : 0;
        if (amp > 8000) amp = 8000;
        step_hi = cfg_sleep_min * SEC_PER_MIN / 2 + 2;
        for (int i = 0; i < len; i++) begin
            for (int k = 0; k < AXES; k++) begin
                d = int'($urandom_range(2 * amp)) - amp;
                pose[k] = clamp_axis(int'(pose[k]) + d);
            end
            if ($urandom_range(99) < 15)
                for (int k = 3; k < AXES; k++) pose[k] = axis_t'($urandom);
            clock_s += $urandom_range(step_hi);
            queue_sample(pose, clock_s);
        end
    endtask

    // Large accel jumps (each axis moves at least 16384) with random gyro
    task automatic active_stretch(input int len);
        int          d;
        int unsigned step_hi;
        step_hi = cfg_wake_min * SEC_PER_MIN / 2 + 2;
        for (int i = 0; i < len; i++) begin
            for (int k = 0; k < 3; k++) begin
                d = int'($urandom_range(32767, 16384));
                if ($urandom_range(1)) d = -d;
                pose[k] = axis_t'(int'(pose[k]) + d);
            end
            for (int k = 3; k < AXES; k++) pose[k] = axis_t'($urandom);
            clock_s += $urandom_range(step_hi);
            queue_sample(pose, clock_s);
        end
    endtask

    // Unstructured items and odd clocks: zero, backwards, near the wrap
    task automatic noise_burst(input int len);
        for (int i = 0; i < len; i++) begin
            for (int k = 0; k < AXES; k++) pose[k] = axis_t'($urandom);
            case ($urandom_range(4))
                0:       clock_s = $urandom;
                1:       clock_s = '0;
                2:       clock_s = clock_s - $urandom_range(100);
                3:       clock_s = 32'hFFFF_FFFF - $urandom_range(400);
                default: ;
            endcase
            queue_sample(pose, clock_s);
        end
    endtask

    // Mostly still-then-active episodes, the rest noise
    task automatic random_phase(input int count);
        int target;
        target = n_queued + count;
        while (n_queued < target) begin
            if ($urandom_range(99) < 70) begin
                if ($urandom_range(9) == 0) clock_s = 32'hFFFF_FFFF - $urandom_range(2000);
                still_stretch($urandom_range(10, 3));
                active_stretch($urandom_range(8, 2));
            end else begin
                noise_burst($urandom_range(4, 1));
            end
        end
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || outcome_due.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_STILL_THR:  cfg_thr       = val;
            CFG_SLEEP_HOLD: cfg_sleep_min = val[HOLD_W-1:0];
            CFG_WAKE_HOLD:  cfg_wake_min  = val[HOLD_W-1:0];
            default:        ;
        endcase
    endtask

    task automatic close_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // Reset defaults: threshold 500, sleep after 600 s, wake after 60 s
    task automatic directed_items();
        queue_pose(AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, 32'd0); // first
        queue_pose(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, 32'd5); // max mag
        queue_pose(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, 32'd0); // arm at 0
        queue_pose(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, 32'd7); // re-arm
        queue_pose(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, 32'd300);
        queue_pose(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, 32'd607); // sleep
        // asleep: gyro swing ignored, then exactly twice the threshold, then just over
        queue_pose(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MAX, AXIS_MAX, AXIS_MAX, 32'd610);
        queue_pose(AXIS_MIN + 1000, AXIS_MIN, AXIS_MIN, AXIS_MAX, AXIS_MAX, AXIS_MAX, 32'd620);
        queue_pose(AXIS_MIN + 1000, AXIS_MIN + 1001, AXIS_MIN, AXIS_MAX, AXIS_MAX, AXIS_MAX,
                   32'd630);
        queue_pose(AXIS_MIN + 1000, AXIS_MIN, AXIS_MIN, AXIS_MAX, AXIS_MAX, AXIS_MAX, 32'd650);
        queue_pose(AXIS_MIN + 1000, AXIS_MIN + 1001, AXIS_MIN, AXIS_MAX, AXIS_MAX, AXIS_MAX,
                   32'd690);                                                      // wake
        // awake: magnitude equal to the threshold, one below, then gyro alone breaks it
        queue_pose(AXIS_MIN + 1500, AXIS_MIN + 1001, AXIS_MIN, AXIS_MAX, AXIS_MAX, AXIS_MAX,
                   32'd700);
        queue_pose(AXIS_MIN + 1001, AXIS_MIN + 1001, AXIS_MIN, AXIS_MAX, AXIS_MAX, AXIS_MAX,
                   32'd710);
        queue_pose(AXIS_MIN + 1001, AXIS_MIN + 1001, AXIS_MIN, AXIS_MAX - 250, AXIS_MAX - 250,
                   AXIS_MAX - 250, 32'd720);
        // hold timer straddling the 32-bit wrap of the clock
        queue_pose(AXIS_MIN + 1001, AXIS_MIN + 1001, AXIS_MIN, AXIS_MAX - 250, AXIS_MAX - 250,
                   AXIS_MAX - 250, 32'hFFFF_FFF0);
        queue_pose(AXIS_MIN + 1001, AXIS_MIN + 1001, AXIS_MIN, AXIS_MAX - 250, AXIS_MAX - 250,
                   AXIS_MAX - 250, 32'hFFFF_FFFF);
        queue_pose(AXIS_MIN + 1001, AXIS_MIN + 1001, AXIS_MIN, AXIS_MAX - 250, AXIS_MAX - 250,
                   AXIS_MAX - 250, 32'h0000_0250);                                // sleep
        queue_pose(16'sh5555, -16'sh2AAB, 16'sh7F00, -16'sh7F01, 16'sh00FF, 16'sh1234,
                   32'hAAAA_5555);
    endtask

    // ---------------------------------------------------------------------
    // Sequence: reset, directed part, then one random phase per setting
    // ---------------------------------------------------------------------
    initial begin : sequencer
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        directed_items();
        wait_drained();         // sender holds off until every result is back

        // zero hold times: transition on the second qualifying sample
        write_reg(CFG_STILL_THR, 19'd3000);
        write_reg(CFG_SLEEP_HOLD, 19'd0);
        write_reg(CFG_WAKE_HOLD, 19'd0);
        close_writes();
        random_phase(110);
        wait_drained();

        // zero threshold, longest sleep hold (written with upper bits set)
        write_reg(CFG_STILL_THR, 19'd0);
        write_reg(CFG_SLEEP_HOLD, 19'h7FFFF);
        write_reg(CFG_WAKE_HOLD, 19'd1);
        close_writes();
        random_phase(40);
        wait_drained();

        // largest threshold: sleeps easily, can never be woken
        write_reg(CFG_STILL_THR, 19'h7FFFF);
        write_reg(CFG_SLEEP_HOLD, 19'd1);
        write_reg(CFG_WAKE_HOLD, 19'd255);
        close_writes();
        random_phase(60);
        wait_drained();

        // threshold of one; a write to the unused index must change nothing
        write_reg(CFG_STILL_THR, 19'd1);
        write_reg(CFG_SLEEP_HOLD, 19'd2);
        write_reg(CFG_WAKE_HOLD, 19'd0);
        write_reg(CFG_UNUSED, 19'h12345);
        close_writes();
        random_phase(100);
        wait_drained();

        // back-to-back stretch with no idling on either side
        write_reg(CFG_STILL_THR, 19'd20000);
        write_reg(CFG_SLEEP_HOLD, 19'd1);
        write_reg(CFG_WAKE_HOLD, 19'd1);
        close_writes();
        calm = 1'b1;
        random_phase(120);
        wait_drained();
        calm = 1'b0;

        // hold values written with junk above bit 7
        write_reg(CFG_STILL_THR, 19'd700);
        write_reg(CFG_SLEEP_HOLD, 19'h7FF03);
        write_reg(CFG_WAKE_HOLD, 19'h00102);
        close_writes();
        random_phase(95);
        wait_drained();

        $display("tb: %0d samples over %0d register settings, %0d results checked",
                 n_accepted, n_settings, n_checked);
        $display("tb: %0d sleep entries and %0d wake-ups seen, %0d mismatches",
                 n_sleeps, n_wakes, mismatches);
        if (mismatches == 0 && outcome_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
